/* hw/rtl/csvl_pkg.sv */
`default_nettype none

package csvl_pkg;

    // Width of the internal byte offsets; offsets wrap at this width.
    localparam int OFFSET_BITS = 24;

    // Width of every offset, line and column field on the result port.
    localparam int FIELD_W = 24;

    // Result payload: start, end, error code, error line, error column.
    localparam int PAYLOAD_W = 4 * FIELD_W + 2;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - PAYLOAD_W;

    // Depth of the queue between the classifier and the result stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] ofs_t;
    typedef logic [FIELD_W-1:0]     field_t;

    localparam field_t LC_MAX = '1;

    // Characters the lexer looks at.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        TK_EMPTY      = 3'd0,
        TK_PLAIN      = 3'd1,
        TK_QUOTED     = 3'd2,
        TK_BOOLEAN    = 3'd3,
        TK_INTEGER    = 3'd4,
        TK_FLOAT      = 3'd5,
        TK_LINE_BREAK = 3'd6,
        TK_ERROR      = 3'd7
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_QUOTE        = 2'd1,
        ERR_AFTER_QUOTE  = 2'd2,
        ERR_SPACE_AFTER  = 2'd3
    } err_code_t;

    typedef enum logic [3:0] {
        LM_NEW   = 4'd0,
        LM_UNQ   = 4'd1,
        LM_INQ   = 4'd2,
        LM_QIQ   = 4'd3,
        LM_T     = 4'd4,
        LM_TR    = 4'd5,
        LM_TRU   = 4'd6,
        LM_TRUE  = 4'd7,
        LM_F     = 4'd8,
        LM_FA    = 4'd9,
        LM_FAL   = 4'd10,
        LM_FALS  = 4'd11,
        LM_FALSE = 4'd12,
        LM_INT   = 4'd13,
        LM_FLT   = 4'd14,
        LM_ERR   = 4'd15
    } lex_mode_t;

    // One queued request: a field token or an error, and whether a
    // line-break token follows it.
    typedef struct packed {
        token_kind_t kind;
        field_t      field_start;
        field_t      field_end;
        err_code_t   code;
        field_t      line;
        field_t      column;
        logic        has_break;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

/* hw/rtl/csvl_front.sv */
`default_nettype none

module csvl_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    command,
    input  wire logic [7:0]              data_byte,
    input  wire csvl_pkg::queue_status_t status,
    output logic                         push,
    output csvl_pkg::job_t               job
);

    csvl_pkg::lex_mode_t mode_reg, mode_next;
    csvl_pkg::ofs_t      origin_reg, origin_next;
    csvl_pkg::ofs_t      offset_reg, offset_next;
    csvl_pkg::field_t    line_reg, line_next;
    csvl_pkg::field_t    col_reg, col_next;
    logic                drop_reg, drop_next;

    logic                accept;
    logic                is_nl;
    logic                is_cr;
    logic                is_comma;
    logic                is_term;
    logic                is_blank;
    logic                emit_field;
    logic                emit_error;
    csvl_pkg::lex_mode_t char_mode;
    csvl_pkg::err_code_t char_code;
    csvl_pkg::field_t    line_inc;
    csvl_pkg::field_t    col_inc;

    function automatic csvl_pkg::lex_mode_t step_mode(csvl_pkg::lex_mode_t m,
                                                     logic [7:0] ch);
        csvl_pkg::lex_mode_t r;
        r = csvl_pkg::LM_UNQ;
        if (ch == csvl_pkg::CH_QUOTE) begin
            if (m == csvl_pkg::LM_NEW || m == csvl_pkg::LM_QIQ) r = csvl_pkg::LM_INQ;
            else if (m == csvl_pkg::LM_INQ) r = csvl_pkg::LM_QIQ;
            else r = csvl_pkg::LM_ERR;
        end
        else if (m == csvl_pkg::LM_INQ) r = csvl_pkg::LM_INQ;
        else if (m == csvl_pkg::LM_QIQ) r = csvl_pkg::LM_ERR;
        else if (ch == csvl_pkg::CH_SPACE || ch == csvl_pkg::CH_TAB) begin
            r = (m == csvl_pkg::LM_NEW) ? csvl_pkg::LM_NEW : csvl_pkg::LM_UNQ;
        end
        else if (ch inside {[csvl_pkg::CH_ZERO:csvl_pkg::CH_NINE]}) begin
            if (m == csvl_pkg::LM_NEW) r = csvl_pkg::LM_INT;
            else if (m == csvl_pkg::LM_INT || m == csvl_pkg::LM_FLT) r = m;
        end
        else if (ch == csvl_pkg::CH_DOT) begin
            if (m == csvl_pkg::LM_NEW || m == csvl_pkg::LM_INT) r = csvl_pkg::LM_FLT;
        end
        else if (m == csvl_pkg::LM_NEW && ch == "t") r = csvl_pkg::LM_T;
        else if (m == csvl_pkg::LM_T && ch == "r") r = csvl_pkg::LM_TR;
        else if (m == csvl_pkg::LM_TR && ch == "u") r = csvl_pkg::LM_TRU;
        else if (m == csvl_pkg::LM_TRU && ch == "e") r = csvl_pkg::LM_TRUE;
        else if (m == csvl_pkg::LM_NEW && ch == "f") r = csvl_pkg::LM_F;
        else if (m == csvl_pkg::LM_F && ch == "a") r = csvl_pkg::LM_FA;
        else if (m == csvl_pkg::LM_FA && ch == "l") r = csvl_pkg::LM_FAL;
        else if (m == csvl_pkg::LM_FAL && ch == "s") r = csvl_pkg::LM_FALS;
        else if (m == csvl_pkg::LM_FALS && ch == "e") r = csvl_pkg::LM_FALSE;
        return r;
    endfunction

    assign in_ready = !status.full;
    assign accept   = in_valid && in_ready;

    assign is_nl    = command || (data_byte == csvl_pkg::CH_LF);
    assign is_cr    = !command && (data_byte == csvl_pkg::CH_CR);
    assign is_comma = !command && (data_byte == csvl_pkg::CH_COMMA);
    assign is_term  = is_nl || (is_cr && mode_reg != csvl_pkg::LM_INQ) || is_comma;
    assign is_blank = (data_byte == csvl_pkg::CH_SPACE) || (data_byte == csvl_pkg::CH_TAB);

    assign char_mode = step_mode(mode_reg, data_byte);
    assign line_inc  = (line_reg == csvl_pkg::LC_MAX) ? line_reg : line_reg + 1'b1;
    assign col_inc   = (col_reg == csvl_pkg::LC_MAX) ? col_reg : col_reg + 1'b1;

    always_comb
    begin
        if (data_byte == csvl_pkg::CH_QUOTE) char_code = csvl_pkg::ERR_QUOTE;
        else if (is_blank) char_code = csvl_pkg::ERR_SPACE_AFTER;
        else char_code = csvl_pkg::ERR_AFTER_QUOTE;
    end

    // A byte counts only when the lexer is live and not skipping the byte
    // after a carriage return.
    assign emit_field = accept && mode_reg != csvl_pkg::LM_ERR && !drop_reg
                        && is_term && mode_reg != csvl_pkg::LM_INQ;
    assign emit_error = accept && mode_reg != csvl_pkg::LM_ERR && !drop_reg
                        && !is_term && char_mode == csvl_pkg::LM_ERR;

    // Next-state logic.
    always_comb
    begin
        mode_next   = mode_reg;
        origin_next = origin_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        drop_next   = drop_reg;
        if (accept && mode_reg != csvl_pkg::LM_ERR) begin
            if (drop_reg) begin
                drop_next   = 1'b0;
                offset_next = offset_reg + csvl_pkg::ofs_t'(1);
            end
            else if (is_term) begin
                offset_next = offset_reg + csvl_pkg::ofs_t'(1);
                if (is_nl || is_cr) begin
                    line_next = line_inc;
                    col_next  = csvl_pkg::field_t'(1);
                end
                else begin
                    col_next = col_inc;
                end
                if (mode_reg != csvl_pkg::LM_INQ) begin
                    origin_next = offset_reg
                                  + (is_cr ? csvl_pkg::ofs_t'(2) : csvl_pkg::ofs_t'(1));
                    mode_next   = csvl_pkg::LM_NEW;
                    drop_next   = is_cr;
                end
            end
            else if (char_mode == csvl_pkg::LM_ERR) begin
                mode_next = csvl_pkg::LM_ERR;
            end
            else begin
                if (mode_reg == csvl_pkg::LM_NEW && char_mode == csvl_pkg::LM_NEW) begin
                    origin_next = origin_reg + csvl_pkg::ofs_t'(1);
                end
                mode_next   = char_mode;
                col_next    = col_inc;
                offset_next = offset_reg + csvl_pkg::ofs_t'(1);
            end
        end
    end

    // Request toward the result stage.
    always_comb
    begin
        push            = emit_field || emit_error;
        job.kind        = csvl_pkg::TK_PLAIN;
        job.field_start = csvl_pkg::field_t'(origin_reg);
        job.field_end   = csvl_pkg::field_t'(offset_reg);
        job.code        = csvl_pkg::ERR_NONE;
        job.line        = '0;
        job.column      = '0;
        job.has_break   = is_nl || is_cr;
        if (emit_error) begin
            job.kind        = csvl_pkg::TK_ERROR;
            job.field_start = '0;
            job.field_end   = '0;
            job.code        = char_code;
            job.line        = line_reg;
            job.column      = col_reg;
            job.has_break   = 1'b0;
        end
        else begin
            case (mode_reg)
                csvl_pkg::LM_NEW:
                begin
                    job.kind      = csvl_pkg::TK_EMPTY;
                    job.field_end = csvl_pkg::field_t'(origin_reg);
                end
                csvl_pkg::LM_QIQ:
                begin
                    job.kind        = csvl_pkg::TK_QUOTED;
                    job.field_start = csvl_pkg::field_t'(origin_reg + csvl_pkg::ofs_t'(1));
                    job.field_end   = csvl_pkg::field_t'(offset_reg - csvl_pkg::ofs_t'(1));
                end
                csvl_pkg::LM_TRUE, csvl_pkg::LM_FALSE: job.kind = csvl_pkg::TK_BOOLEAN;
                csvl_pkg::LM_INT: job.kind = csvl_pkg::TK_INTEGER;
                csvl_pkg::LM_FLT: job.kind = csvl_pkg::TK_FLOAT;
                default: job.kind = csvl_pkg::TK_PLAIN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= csvl_pkg::LM_NEW;
            origin_reg <= '0;
            offset_reg <= '0;
            line_reg   <= csvl_pkg::field_t'(1);
            col_reg    <= csvl_pkg::field_t'(1);
            drop_reg   <= 1'b0;
        end
        else begin
            mode_reg   <= mode_next;
            origin_reg <= origin_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            drop_reg   <= drop_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Once an error is reported the lexer never leaves the error mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == csvl_pkg::LM_ERR |=> mode_reg == csvl_pkg::LM_ERR)
        else $error("lexer left the error mode");

    // A skipped byte after a carriage return always follows a line end.
    assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> mode_reg == csvl_pkg::LM_NEW)
        else $error("byte skip pending outside a new field");
`endif

endmodule

`default_nettype wire

/* hw/rtl/csvl_queue.sv */
`default_nettype none

module csvl_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire csvl_pkg::job_t          push_job,
    input  wire logic                    pop,
    output csvl_pkg::job_t               head,
    output csvl_pkg::queue_status_t      status
);

    csvl_pkg::job_t               entry_reg [csvl_pkg::QUEUE_DEPTH];
    logic [csvl_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [csvl_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [csvl_pkg::QCNT_W-1:0]  count_reg, count_next;

    localparam logic [csvl_pkg::QPTR_W-1:0] PTR_LAST =
        csvl_pkg::QPTR_W'(csvl_pkg::QUEUE_DEPTH - 1);

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == csvl_pkg::QCNT_W'(csvl_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop))
        else $error("request written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("request taken from an empty queue");
`endif

endmodule

`default_nettype wire

/* hw/rtl/csvl_back.sv */
`default_nettype none

module csvl_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire csvl_pkg::job_t               head,
    input  wire csvl_pkg::queue_status_t      status,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [csvl_pkg::TDATA_W-1:0]      out_data,
    output logic [2:0]                        out_kind,
    output logic                              out_last
);

    logic                             valid_reg, valid_next;
    logic                             break_reg, break_next;
    logic [csvl_pkg::TDATA_W-1:0]     data_reg, data_next;
    csvl_pkg::token_kind_t            kind_reg, kind_next;
    logic                             last_reg, last_next;
    logic                             load;

    assign load = !valid_reg || out_ready;
    assign pop  = load && !break_reg && !status.empty;

    always_comb
    begin
        valid_next = valid_reg;
        break_next = break_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (load) begin
            if (break_reg) begin
                valid_next = 1'b1;
                break_next = 1'b0;
                data_next  = '0;
                kind_next  = csvl_pkg::TK_LINE_BREAK;
                last_next  = 1'b1;
            end
            else if (!status.empty) begin
                valid_next = 1'b1;
                break_next = head.has_break;
                data_next  = {{csvl_pkg::PAD_W{1'b0}}, head.column, head.line,
                              head.code, head.field_end, head.field_start};
                kind_next  = head.kind;
                last_next  = !head.has_break;
            end
            else begin
                valid_next = 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            break_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
            break_reg <= break_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

`ifndef NO_ASSERTIONS
    // A pending line break always sits behind a field token on the port.
    assert property (@(posedge clk) disable iff (!rst_n)
        break_reg |-> valid_reg && !last_reg)
        else $error("line break pending without a field token shown");
`endif

endmodule

`default_nettype wire

/* hw/rtl/csv_token_lexer.sv */
`default_nettype none

// CSV tokenizer that takes one byte per cycle on the input stream and emits
// one token per comma or line end, plus a line-break token after each line
// end. An input request is a data byte in s_tdata, or an end marker
// (s_tuser high) that acts as a final newline. A carriage return outside
// quotes ends the line and the byte after it is skipped. Each field token
// carries its kind (empty, plain, quoted, boolean, integer, float) and its
// start and end byte offsets, the end being just past the field data with
// quotes excluded. A malformed quote gives a single error token with line and
// column; after that every input is taken and dropped until reset.
// Rate: the classifier accepts a byte in every cycle while the four-entry
// request queue has room, and the result register delivers one token per
// cycle while the receiver is ready, so a line end yields two tokens; with
// short lines the sustained rate is set by the result port, about one byte
// per cycle otherwise. A request passes from the classifier into the queue
// and from the queue into the output register. Leading blanks before a
// field are skipped; trimming of the whole text is the feeder's job. No
// clearing pass is needed after reset.
module csv_token_lexer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // [7:0] data_byte
    input  wire logic                         s_tuser,  // [0] command (1 = end of input)
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [23:0] field_start, [47:24] field_end, [49:48] error_code,
    // [73:50] error_line, [97:74] error_column, upper bits zero
    output logic [csvl_pkg::TDATA_W-1:0]      m_tdata,
    output logic [2:0]                        m_tuser,  // [2:0] token_kind
    output logic                              m_tlast
);

    csvl_pkg::queue_status_t status;
    csvl_pkg::job_t          push_job;
    csvl_pkg::job_t          head;
    logic                    push;
    logic                    pop;

    // Classifier: keeps the lexer state and turns bytes into token requests.
    csvl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tuser),
        .data_byte (s_tdata),
        .status    (status),
        .push      (push),
        .job       (push_job)
    );

    // Short queue so the input side keeps running while results stall.
    csvl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    // Result stage: one token per cycle while the receiver is ready, line break after a line-end token.
    csvl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

/* verif/csv_token_lexer_tb.sv */
`timescale 1ns / 1ps

module csv_token_lexer_tb;

    // The run is stopped here if the block hangs.
    localparam int CYCLE_LIMIT = 1000000;
    // Cycles allowed after the last expected token before the verdict.
    localparam int DRAIN_CYCLES = 16;
    // Total request count at which the random part stops.
    localparam int RANDOM_REQUESTS = 1250;

    // One token as it should leave the result port.
    typedef struct {
        csvl_pkg::token_kind_t kind;
        csvl_pkg::field_t      start;
        csvl_pkg::field_t      stop;
        csvl_pkg::err_code_t   code;
        csvl_pkg::field_t      line;
        csvl_pkg::field_t      column;
        logic                  last;
    } token_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = 8'h00;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [csvl_pkg::TDATA_W-1:0]  m_tdata;
    logic [2:0]                    m_tuser;
    logic                          m_tlast;

    // Lexer state as the block should hold it after every accepted request.
    csvl_pkg::lex_mode_t lx_mode;
    csvl_pkg::ofs_t      lx_origin;
    csvl_pkg::ofs_t      lx_offset;
    csvl_pkg::field_t    lx_line;
    csvl_pkg::field_t    lx_column;
    logic                lx_skip;

    // Tokens that the block still owes, oldest first.
    token_t    pending_tokens[$];

    int        failures = 0;
    int        requests_sent = 0;
    int        cycle_count = 0;
    // When set, the sender or the receiver runs without any idle cycles.
    logic      tx_steady = 1'b0;
    logic      rx_steady = 1'b0;

    csv_token_lexer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[csv_token_lexer] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic csvl_pkg::field_t sat_inc(input csvl_pkg::field_t v);
        return (v == csvl_pkg::LC_MAX) ? v : csvl_pkg::field_t'(v + 1);
    endfunction

    function automatic token_t make_token(input csvl_pkg::token_kind_t kind,
                                          input csvl_pkg::field_t start,
                                          input csvl_pkg::field_t stop,
                                          input csvl_pkg::err_code_t code,
                                          input csvl_pkg::field_t line,
                                          input csvl_pkg::field_t column,
                                          input logic last);
        token_t tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.stop   = stop;
        tok.code   = code;
        tok.line   = line;
        tok.column = column;
        tok.last   = last;
        return tok;
    endfunction

    // Error raised by a byte that does not close a field, or ERR_NONE.
    // A quote may only open a field, close a quoted one or be doubled inside
    // it; after a closing quote only a terminator or a second quote may follow.
    function automatic csvl_pkg::err_code_t fault_code(input csvl_pkg::lex_mode_t m,
                                                       input logic [7:0] ch);
        if (ch == csvl_pkg::CH_QUOTE)
            return (m == csvl_pkg::LM_NEW || m == csvl_pkg::LM_INQ || m == csvl_pkg::LM_QIQ)
                   ? csvl_pkg::ERR_NONE : csvl_pkg::ERR_QUOTE;
        if (m == csvl_pkg::LM_QIQ)
            return (ch == csvl_pkg::CH_SPACE || ch == csvl_pkg::CH_TAB)
                   ? csvl_pkg::ERR_SPACE_AFTER : csvl_pkg::ERR_AFTER_QUOTE;
        return csvl_pkg::ERR_NONE;
    endfunction

    // Field classification for a byte that neither closes a field nor faults.
    function automatic csvl_pkg::lex_mode_t advance_mode(input csvl_pkg::lex_mode_t m,
                                                         input logic [7:0] ch);
        if (ch == csvl_pkg::CH_QUOTE)
            return (m == csvl_pkg::LM_INQ) ? csvl_pkg::LM_QIQ : csvl_pkg::LM_INQ;
        if (m == csvl_pkg::LM_INQ)
            return csvl_pkg::LM_INQ;
        if (ch == csvl_pkg::CH_SPACE || ch == csvl_pkg::CH_TAB)
            return (m == csvl_pkg::LM_NEW) ? csvl_pkg::LM_NEW : csvl_pkg::LM_UNQ;
        if (ch >= csvl_pkg::CH_ZERO && ch <= csvl_pkg::CH_NINE)
        begin
            if (m == csvl_pkg::LM_NEW)
                return csvl_pkg::LM_INT;
            return (m == csvl_pkg::LM_INT || m == csvl_pkg::LM_FLT) ? m : csvl_pkg::LM_UNQ;
        end
        if (ch == csvl_pkg::CH_DOT)
            return (m == csvl_pkg::LM_NEW || m == csvl_pkg::LM_INT)
                   ? csvl_pkg::LM_FLT : csvl_pkg::LM_UNQ;
        if (m == csvl_pkg::LM_NEW && ch == "t")
            return csvl_pkg::LM_T;
        if (m == csvl_pkg::LM_T && ch == "r")
            return csvl_pkg::LM_TR;
        if (m == csvl_pkg::LM_TR && ch == "u")
            return csvl_pkg::LM_TRU;
        if (m == csvl_pkg::LM_TRU && ch == "e")
            return csvl_pkg::LM_TRUE;
        if (m == csvl_pkg::LM_NEW && ch == "f")
            return csvl_pkg::LM_F;
        if (m == csvl_pkg::LM_F && ch == "a")
            return csvl_pkg::LM_FA;
        if (m == csvl_pkg::LM_FA && ch == "l")
            return csvl_pkg::LM_FAL;
        if (m == csvl_pkg::LM_FAL && ch == "s")
            return csvl_pkg::LM_FALS;
        if (m == csvl_pkg::LM_FALS && ch == "e")
            return csvl_pkg::LM_FALSE;
        return csvl_pkg::LM_UNQ;
    endfunction

    // A line feed, a comma, an end marker, or a carriage return outside
    // quotes closes the current field.
    function automatic logic closes_field(input logic cmd, input logic [7:0] ch);
        return cmd || ch == csvl_pkg::CH_LF || ch == csvl_pkg::CH_COMMA
               || (ch == csvl_pkg::CH_CR && lx_mode != csvl_pkg::LM_INQ);
    endfunction

    function automatic logic would_fault(input logic cmd, input logic [7:0] ch);
        if (lx_mode == csvl_pkg::LM_ERR || lx_skip || closes_field(cmd, ch))
            return 1'b0;
        return fault_code(lx_mode, ch) != csvl_pkg::ERR_NONE;
    endfunction

    // Advances the lexer state by one accepted request and queues the
    // tokens it should produce.
    task automatic tokenize_request(input logic cmd, input logic [7:0] ch);
        csvl_pkg::ofs_t        pos;
        logic                  line_end;
        logic                  is_cr;
        csvl_pkg::err_code_t   code;
        csvl_pkg::token_kind_t kind;
        csvl_pkg::field_t      start;
        csvl_pkg::field_t      stop;
        pos = lx_offset;
        if (lx_mode == csvl_pkg::LM_ERR)
            return;
        // The byte after a carriage return only moves the offset.
        if (lx_skip)
        begin
            lx_skip = 1'b0;
            lx_offset = lx_offset + 1'b1;
            return;
        end
        is_cr = !cmd && ch == csvl_pkg::CH_CR;
        line_end = cmd || ch == csvl_pkg::CH_LF;
        if (closes_field(cmd, ch))
        begin
            if (line_end || is_cr)
            begin
                lx_line = sat_inc(lx_line);
                lx_column = '0;
            end
            // Inside quotes a line end is field data; only the counters move.
            if (lx_mode != csvl_pkg::LM_INQ)
            begin
                start = lx_origin;
                stop = pos;
                case (lx_mode)
                    csvl_pkg::LM_NEW:
                    begin
                        kind = csvl_pkg::TK_EMPTY;
                        stop = lx_origin;
                    end
                    csvl_pkg::LM_QIQ:
                    begin
                        kind = csvl_pkg::TK_QUOTED;
                        start = lx_origin + 1'b1;
                        stop = pos - 1'b1;
                    end
                    csvl_pkg::LM_TRUE, csvl_pkg::LM_FALSE: kind = csvl_pkg::TK_BOOLEAN;
                    csvl_pkg::LM_INT:                      kind = csvl_pkg::TK_INTEGER;
                    csvl_pkg::LM_FLT:                      kind = csvl_pkg::TK_FLOAT;
                    default:                               kind = csvl_pkg::TK_PLAIN;
                endcase
                pending_tokens.push_back(make_token(kind, start, stop, csvl_pkg::ERR_NONE,
                                                    '0, '0, !(line_end || is_cr)));
                if (line_end || is_cr)
                    pending_tokens.push_back(make_token(csvl_pkg::TK_LINE_BREAK, '0, '0,
                                                        csvl_pkg::ERR_NONE, '0, '0, 1'b1));
                lx_origin = pos + csvl_pkg::ofs_t'(is_cr ? 2 : 1);
                lx_mode = csvl_pkg::LM_NEW;
                lx_skip = is_cr;
            end
        end
        else
        begin
            code = fault_code(lx_mode, ch);
            if (code != csvl_pkg::ERR_NONE)
            begin
                pending_tokens.push_back(make_token(csvl_pkg::TK_ERROR, '0, '0, code,
                                                    lx_line, lx_column, 1'b1));
                lx_mode = csvl_pkg::LM_ERR;
                return;
            end
            // Blanks ahead of a field push its start along.
            if (lx_mode == csvl_pkg::LM_NEW && advance_mode(lx_mode, ch) == csvl_pkg::LM_NEW)
                lx_origin = lx_origin + 1'b1;
            lx_mode = advance_mode(lx_mode, ch);
        end
        lx_column = sat_inc(lx_column);
        lx_offset = lx_offset + 1'b1;
    endtask

    // Offers one request after a random gap, or none while tx_steady is set, and
    // waits for its handshake. Inputs only change at the falling edge.
    task automatic send_request(input logic cmd, input logic [7:0] ch);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tokenize_request(cmd, ch);
        requests_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_request(1'b0, text[i]);
    endtask

    // Random traffic must not trip the lockup: a byte that would fault is
    // swapped for one that keeps the lexer going.
    task automatic send_clean(input logic cmd, input logic [7:0] ch);
        if (would_fault(cmd, ch))
            ch = (lx_mode == csvl_pkg::LM_QIQ) ? csvl_pkg::CH_COMMA : "x";
        send_request(cmd, ch);
    endtask

    task automatic send_clean_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_clean(1'b0, text[i]);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Every token taken from the result port is matched against the oldest
    // expectation.
    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token_kind: expected no token, got %0d", m_tuser);
                failures++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 32'(want.kind), 32'(m_tuser));
                check_field("field_start", 32'(want.start), 32'(m_tdata[23:0]));
                check_field("field_end", 32'(want.stop), 32'(m_tdata[47:24]));
                check_field("error_code", 32'(want.code), 32'(m_tdata[49:48]));
                check_field("error_line", 32'(want.line), 32'(m_tdata[73:50]));
                check_field("error_column", 32'(want.column), 32'(m_tdata[97:74]));
                check_field("padding", 0,
                            32'(m_tdata[csvl_pkg::TDATA_W-1:csvl_pkg::PAYLOAD_W]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Receiver pacing: bursts of ready with random stalls between them,
    // unless a steady stretch is running.
    initial
    begin : result_pacing
        int stall;
        int run;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_steady ? 0 : pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run - 1) @(negedge clk);
        end
    end

    // Every unquoted field kind, blanks ahead of a field, and the extreme byte values.
    task automatic test_field_kinds();
        send_text(" true,false,42,,7.5,.,x\t,");
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Quoted fields with a doubled quote, a comma, a line feed and a carriage
    // return inside, and an end marker that falls inside the quotes.
    task automatic test_quoted_fields();
        send_text("\"a,\"\"\n\r\",");
        send_text("\"q");
        send_request(1'b1, 8'($urandom_range(0, 255)));
        send_text("\"\n");
    endtask

    // A carriage return ends the line and swallows the next request, be it a
    // line feed, any byte or an end marker.
    task automatic test_line_ends();
        send_text("1\r\n2\rZ\r");
        send_request(1'b1, 8'($urandom_range(0, 255)));
        send_text("9");
        send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed records with random content, some raw noise, and
    // random line endings; the pacing switches between idle and steady.
    task automatic test_random_records();
        string      text;
        int         pick;
        logic [7:0] ch;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    send_clean(1'b0, $urandom_range(0, 1) ? csvl_pkg::CH_SPACE
                                                           : csvl_pkg::CH_TAB);
            case ($urandom_range(0, 6))
                0: ;  // empty field
                1:
                begin
                    pick = $urandom_range(0, 5);
                    if (pick < 2)
                        text = "true";
                    else if (pick < 4)
                        text = "false";
                    else if (pick == 4)
                        text = "tru";
                    else
                        text = "falsey";
                    send_clean_text(text);
                end
                2:
                    repeat ($urandom_range(1, 4))
                        send_clean(1'b0, 8'($urandom_range(csvl_pkg::CH_ZERO,
                                                           csvl_pkg::CH_NINE)));
                3:
                begin
                    pick = $urandom_range(0, 2);
                    if (pick != 1)
                        repeat ($urandom_range(1, 3))
                            send_clean(1'b0, 8'($urandom_range(csvl_pkg::CH_ZERO,
                                                               csvl_pkg::CH_NINE)));
                    send_clean(1'b0, csvl_pkg::CH_DOT);
                    if (pick != 2)
                        repeat ($urandom_range(1, 3))
                            send_clean(1'b0, 8'($urandom_range(csvl_pkg::CH_ZERO,
                                                               csvl_pkg::CH_NINE)));
                end
                4:
                    repeat ($urandom_range(1, 5))
                        send_clean(1'b0, 8'($urandom_range("a", "z")));
                5:
                begin
                    send_clean(1'b0, csvl_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(0, 6) == 0)
                            send_clean_text("\"\"");
                        else
                        begin
                            ch = 8'($urandom_range(0, 255));
                            send_clean(1'b0, (ch == csvl_pkg::CH_QUOTE)
                                             ? csvl_pkg::CH_COMMA : ch);
                        end
                    end
                    send_clean(1'b0, csvl_pkg::CH_QUOTE);
                end
                default:
                    repeat ($urandom_range(1, 4))
                        send_clean(1'b0, 8'($urandom_range(0, 255)));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_clean(1'b0, csvl_pkg::CH_COMMA);
            else if (pick < 75)
                send_clean(1'b0, csvl_pkg::CH_LF);
            else if (pick < 90)
            begin
                send_clean(1'b0, csvl_pkg::CH_CR);
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_clean(1'b0, csvl_pkg::CH_LF);
                else if (pick < 65)
                    send_clean(1'b1, 8'($urandom_range(0, 255)));
                else
                    send_clean(1'b0, 8'($urandom_range(0, 255)));
            end
            else
                send_clean(1'b1, 8'($urandom_range(0, 255)));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // One malformed quote, picked at random, then the block must stay silent
    // whatever it is given. Only one fault fits in a run with a single reset.
    task automatic test_fault_lockup();
        if (lx_skip)
            send_request(1'b0, "x");
        if (lx_mode == csvl_pkg::LM_INQ)
            send_request(1'b0, csvl_pkg::CH_QUOTE);
        send_text("\nab,\"c\"\nxy,");
        case ($urandom_range(0, 2))
            0: send_text("zz\"");
            1: send_text("\"ok\"q");
            default:
            begin
                send_text("\"ok\"");
                send_request(1'b0, $urandom_range(0, 1) ? csvl_pkg::CH_SPACE
                                                         : csvl_pkg::CH_TAB);
            end
        endcase
        repeat (30)
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        lx_mode   = csvl_pkg::LM_NEW;
        lx_origin = '0;
        lx_offset = '0;
        lx_line   = csvl_pkg::field_t'(1);
        lx_column = csvl_pkg::field_t'(1);
        lx_skip   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_kinds();
        test_quoted_fields();
        test_line_ends();
        test_random_records();
        test_fault_lockup();

        @(negedge clk);
        s_tvalid <= 1'b0;
        // Wait for every owed token, then give stray ones time to show up.
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("[csv_token_lexer] OK");
        else
            $display("[csv_token_lexer] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/csvl_pkg.sv
hw/rtl/csvl_front.sv
hw/rtl/csvl_queue.sv
hw/rtl/csvl_back.sv
hw/rtl/csv_token_lexer.sv
verif/csv_token_lexer_tb.sv
